// File: rtl/plc_pkg.sv
// shared types and constants for the positional list engine
package plc_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned DEPTH_MAX = 256;
    localparam int unsigned IDX_MAX_W = $clog2(DEPTH_MAX);
    localparam int unsigned DATA_W    = 32;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_DELETE  = 3'd1,
        OP_FIND    = 3'd2,
        OP_READ    = 3'd3,
        OP_REVERSE = 3'd4,
        OP_LENGTH  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DEL,
        S_REV,
        S_DONE
    } t_state;

    // what every cell does this cycle
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INS,
        CM_DEL,
        CM_ROT
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode           mode;
        logic [IDX_MAX_W-1:0] idx;
        logic [DATA_W-1:0]    value;
    } t_cell_ctl;

endpackage

// File: rtl/plc_cell.sv
// one list cell: holds one entry and takes from its neighbors on command
module plc_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                      i_clk,
    input  plc_pkg::t_cell_ctl        i_ctl,
    input  logic [plc_pkg::DATA_W-1:0] i_head,
    input  logic [plc_pkg::DATA_W-1:0] i_left,
    input  logic [plc_pkg::DATA_W-1:0] i_right,
    output logic [plc_pkg::DATA_W-1:0] o_data
);
    import plc_pkg::*;

    localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(INDEX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.mode)
            CM_INS: begin
                if (MY_IDX == i_ctl.idx) begin
                    n_data = i_ctl.value;
                end else if (MY_IDX > i_ctl.idx) begin
                    n_data = i_left;
                end
            end
            CM_DEL: begin
                if (MY_IDX >= i_ctl.idx) begin
                    n_data = i_right;
                end
            end
            // shift toward the head below the limit, head value lands at the limit
            CM_ROT: begin
                if (MY_IDX < i_ctl.idx) begin
                    n_data = i_right;
                end else if (MY_IDX == i_ctl.idx) begin
                    n_data = i_head;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: rtl/positional_list_engine_top.sv
// bounded ordered list built from a chain of cells with a sequencing controller
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_opcode, i_position, i_operand_value
//  out     | from block| o_out_valid / i_out_stall | o_result_value, o_found_position,
//          |           |                           | o_list_length, o_status
//
// one transaction at a time. find, read and delete: the head cell is read while
// the first count cells rotate one full turn. reverse: one cell moved per cycle.
// reset clears the length, state and output valid; cell contents stay as they are.
// a stalled result holds in the output register; the next transaction is taken meanwhile.
module positional_list_engine_top #(
    parameter int unsigned DEPTH = plc_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [5:0]  i_position,
    input  logic signed [31:0] i_operand_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [31:0] o_result_value,
    output logic [4:0]  o_found_position,
    output logic [4:0]  o_list_length,
    output logic [1:0]  o_status
);
    import plc_pkg::*;

    localparam int unsigned IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = ((CW > 6) ? CW : 6) + 1;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [IDXW-1:0]     r_k, n_k;
    t_op                 r_op, n_op;
    logic [5:0]          r_pos, n_pos;
    logic [DATA_W-1:0]   r_key, n_key;
    logic [DATA_W-1:0]   r_res_value, n_res_value;
    logic [4:0]          r_res_found, n_res_found;
    logic                r_hit, n_hit;
    t_status             r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_value, n_out_value;
    logic [4:0]          r_out_found, n_out_found;
    logic [4:0]          r_out_length, n_out_length;
    t_status             r_out_status, n_out_status;

    t_cell_ctl           w_ctl;
    logic [DATA_W-1:0]   w_data [DEPTH];
    logic [CMPW-1:0]     w_pos_x;
    logic [CMPW-1:0]     w_cnt_x;
    t_op                 w_op;

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        plc_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_head  (w_data[0]),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g])
        );
    end

    assign w_pos_x = CMPW'(i_position);
    assign w_cnt_x = CMPW'(r_count);
    assign w_op    = t_op'(i_opcode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k          <= n_k;
        r_op         <= n_op;
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_res_value  <= n_res_value;
        r_res_found  <= n_res_found;
        r_hit        <= n_hit;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_found  <= n_out_found;
        r_out_length <= n_out_length;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_k          = r_k;
        n_op         = r_op;
        n_pos        = r_pos;
        n_key        = r_key;
        n_res_value  = r_res_value;
        n_res_found  = r_res_found;
        n_hit        = r_hit;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_value  = r_out_value;
        n_out_found  = r_out_found;
        n_out_length = r_out_length;
        n_out_status = r_out_status;
        w_ctl        = '{mode: CM_HOLD, idx: '0, value: '0};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = w_op;
                    n_pos        = i_position;
                    n_key        = i_operand_value;
                    n_res_value  = '0;
                    n_res_found  = '0;
                    n_hit        = 1'b0;
                    n_res_status = ST_OK;
                    n_k          = '0;
                    n_state      = S_DONE;
                    unique case (w_op)
                        OP_INSERT: begin
                            if (i_position == 6'd0 || w_pos_x > w_cnt_x + CMPW'(1)) begin
                                n_res_status = ST_BADPOS;
                            end else if (r_count == CW'(DEPTH)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                w_ctl.mode  = CM_INS;
                                w_ctl.idx   = IDX_MAX_W'(i_position - 6'd1);
                                w_ctl.value = i_operand_value;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        OP_DELETE, OP_READ: begin
                            if (i_position == 6'd0 || w_pos_x > w_cnt_x) begin
                                n_res_status = ST_BADPOS;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_FIND: begin
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_REVERSE: begin
                            if (r_count > CW'(1)) begin
                                n_k     = IDXW'(r_count - CW'(1));
                                n_state = S_REV;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            // rotate the live entries one full turn, the head cell shows entry r_k
            S_SCAN: begin
                w_ctl.mode = CM_ROT;
                w_ctl.idx  = IDX_MAX_W'(r_count - CW'(1));
                if (r_op == OP_FIND) begin
                    if (!r_hit && w_data[0] == r_key) begin
                        n_hit       = 1'b1;
                        n_res_found = 5'(CMPW'(r_k) + CMPW'(1));
                    end
                end else if (CMPW'(r_k) + CMPW'(1) == CMPW'(r_pos)) begin
                    n_res_value = w_data[0];
                end
                n_k = r_k + IDXW'(1);
                if (CW'(r_k) == r_count - CW'(1)) begin
                    n_state = (r_op == OP_DELETE) ? S_DEL : S_DONE;
                end
            end
            S_DEL: begin
                w_ctl.mode = CM_DEL;
                w_ctl.idx  = IDX_MAX_W'(r_pos - 6'd1);
                n_count    = r_count - CW'(1);
                n_state    = S_DONE;
            end
            // take the head and drop it at the shrinking tail limit
            S_REV: begin
                w_ctl.mode = CM_ROT;
                w_ctl.idx  = IDX_MAX_W'(r_k);
                n_k        = r_k - IDXW'(1);
                if (r_k == IDXW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_found  = r_res_found;
                    n_out_length = 5'(r_count);
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_result_value   = r_out_value;
    assign o_found_position = r_out_found;
    assign o_list_length    = r_out_length;
    assign o_status         = r_out_status;

    a_seq_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("transaction accepted while previous one still in progress");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list length beyond depth");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> o_list_length == 5'(DEPTH))
        else $error("full status reported with list not full");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_k) < r_count))
        else $error("scan index past list length");

endmodule
